// ----- hw/rtl/ibfd_pkg.sv -----
// Package for the iBUS frame decoder: constants, state encoding, control structs.
`default_nettype none
package ibfd_pkg;

  localparam int NUM_CHANNELS_DEF = 14;
  localparam int FRAME_CHANNELS   = 14;

  localparam logic [7:0]  LEN_BYTE       = 8'h20;
  localparam logic [7:0]  CMD_BYTE       = 8'h40;
  localparam logic [15:0] CK_BASE        = 16'hFFFF;
  localparam logic [4:0]  POS_BODY_START = 5'd2;
  localparam logic [4:0]  POS_CK_LOW     = 5'd30;
  localparam logic [4:0]  POS_LAST       = 5'd31;
  localparam logic [12:0] SUM_START      = 13'h060;

  typedef enum logic [1:0] {
    ST_LEN  = 2'd0,
    ST_CMD  = 2'd1,
    ST_BODY = 2'd2,
    ST_EMIT = 2'd3
  } phase_t;

  typedef struct packed {
    logic start_body;
    logic body_byte;
    logic ck_low;
    logic emit_clear;
    logic emit_next;
  } dp_cmd_t;

  typedef struct packed {
    logic is_len;
    logic is_cmd;
    logic pos_ck_low;
    logic pos_last;
    logic ck_ok;
    logic emit_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ibfd_ctrl.sv -----
// Frame parser state machine: sequences search, body capture, check and result burst.
`default_nettype none
module ibfd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  ibfd_pkg::dp_status_t status,
  output ibfd_pkg::dp_cmd_t    cmd
);
  import ibfd_pkg::*;

  phase_t state;
  phase_t state_next;
  logic   in_acc;
  logic   out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LEN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LEN: begin
        if (in_acc && status.is_len) state_next = ST_CMD;
      end
      ST_CMD: begin
        if (in_acc) begin
          priority if (status.is_cmd) state_next = ST_BODY;
          else if (status.is_len) state_next = ST_CMD;
          else state_next = ST_LEN;
        end
      end
      ST_BODY: begin
        if (in_acc && status.pos_last) begin
          state_next = status.ck_ok ? ST_EMIT : ST_LEN;
        end
      end
      ST_EMIT: begin
        if (out_acc && status.emit_last) state_next = ST_LEN;
      end
      default: state_next = ST_LEN;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_LEN: ;
      ST_CMD: begin
        cmd.start_body = in_acc && status.is_cmd;
      end
      ST_BODY: begin
        cmd.body_byte  = in_acc && !status.pos_ck_low && !status.pos_last;
        cmd.ck_low     = in_acc && status.pos_ck_low;
        cmd.emit_clear = in_acc && status.pos_last;
      end
      ST_EMIT: begin
        in_stall      = 1'b1;
        out_valid     = 1'b1;
        cmd.emit_next = out_acc;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ibfd_datapath.sv -----
// Frame datapath: position, running sum, checksum, channel store and result counter.
`default_nettype none
module ibfd_datapath #(
  parameter int NUM_CHANNELS = ibfd_pkg::NUM_CHANNELS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire [7:0]            rx_byte,
  input  ibfd_pkg::dp_cmd_t    cmd,
  output ibfd_pkg::dp_status_t status,
  output logic [3:0]           channel_index,
  output logic [15:0]          channel_value,
  output logic                 last_channel
);
  import ibfd_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [4:0]  pos;
  logic [12:0] sum;
  logic [7:0]  ck_lo;
  logic [7:0]  low_tmp;
  logic [15:0] store [NUM_CHANNELS];
  logic [IDX_W-1:0] emit_cnt;
  logic [3:0]  ch;
  logic [15:0] ck_word;

  assign ch      = pos[4:1] - 4'd1;
  assign ck_word = {rx_byte, ck_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      sum      <= '0;
      ck_lo    <= '0;
      emit_cnt <= '0;
    end else begin
      if (cmd.start_body) begin
        pos <= POS_BODY_START;
        sum <= SUM_START;
      end
      if (cmd.body_byte) begin
        pos <= pos + 5'd1;
        sum <= sum + {5'b0, rx_byte};
      end
      if (cmd.ck_low) begin
        ck_lo <= rx_byte;
        pos   <= pos + 5'd1;
      end
      if (cmd.emit_clear) emit_cnt <= '0;
      if (cmd.emit_next)  emit_cnt <= emit_cnt + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.body_byte) begin
      if (!pos[0]) begin
        low_tmp <= rx_byte;
      end else if (ch < 4'(NUM_CHANNELS)) begin
        store[ch[IDX_W-1:0]] <= {rx_byte, low_tmp};
      end
    end
  end

  assign status.is_len     = (rx_byte == LEN_BYTE);
  assign status.is_cmd     = (rx_byte == CMD_BYTE);
  assign status.pos_ck_low = (pos == POS_CK_LOW);
  assign status.pos_last   = (pos == POS_LAST);
  assign status.ck_ok      = ((CK_BASE - {3'b0, sum}) == ck_word);
  assign status.emit_last  = (emit_cnt == IDX_W'(NUM_CHANNELS - 1));

  assign channel_index = 4'(emit_cnt);
  assign channel_value = store[emit_cnt];
  assign last_channel  = status.emit_last;

endmodule
`default_nettype wire

// ----- hw/rtl/ibus_frame_decoder_core.sv -----
// Top level of the iBUS frame decoder: controller plus datapath.
// One received byte is taken per cycle while the block searches for or receives a
// frame. When the last byte of a frame with a good checksum arrives, the block
// stalls its input and delivers NUM_CHANNELS results, one per cycle while the
// output is not stalled, the last one marked; the output counter in the datapath
// sets that burst length. A frame is 32 bytes long. A bad frame gives no results
// and does not stall the input. No clearing pass is needed after reset.
`default_nettype none
module ibus_frame_decoder_core #(
  parameter int NUM_CHANNELS = ibfd_pkg::NUM_CHANNELS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [7:0]   rx_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic        last_channel
);
  import ibfd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ibfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ibfd_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .cmd           (cmd),
    .status        (status),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .last_channel  (last_channel)
  );

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_channel |=> !out_valid)
    else $error("result burst continues after last item");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_channel |=>
      out_valid && (channel_index == $past(channel_index) + 4'd1))
    else $error("channel index did not advance by one");

  a_burst_starts_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (channel_index == 4'd0))
    else $error("result burst does not start at channel zero");

  a_no_input_in_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during result burst");

endmodule
`default_nettype wire
